@@ hw/rtl/ldr_pkg.sv @@
// ----------------------------------------------------------------------------
// ldr_pkg: shared constants for the longest distinct run block
// Field widths of the stream words and defaults for the block parameters.
// ----------------------------------------------------------------------------
package ldr_pkg;

  // Input word: one sequence element
  localparam int DATA_BITS          = 32;

  // Result word: longest run, padded to a whole byte
  localparam int LONGEST_BITS       = 7;
  localparam int OUT_TDATA_BITS     = 8;
  localparam int LONGEST_MAX        = 127;

  // Parameter defaults
  localparam int WINDOW_DEFAULT     = 64;
  localparam int VALUE_BITS_DEFAULT = 32;

endpackage

@@ hw/rtl/ldr_window.sv @@
// ----------------------------------------------------------------------------
// ldr_window: shift window of the current repeat-free run
// Compares a key against every held entry at once, reports the matching
// position, drops that entry and all older ones, and shifts the key in.
// ----------------------------------------------------------------------------
module ldr_window #(
  parameter int WINDOW     = ldr_pkg::WINDOW_DEFAULT,
  parameter int VALUE_BITS = ldr_pkg::VALUE_BITS_DEFAULT,
  parameter int LEN_BITS   = $clog2(WINDOW + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  shift_en,
  input  logic                  clear,
  input  logic [VALUE_BITS-1:0] key,
  output logic                  hit,
  output logic [LEN_BITS-1:0]   hit_len
);

  localparam int IdxBits = $clog2(WINDOW);

  logic [VALUE_BITS-1:0] window_value [WINDOW];
  logic [WINDOW-1:0]     window_valid;

  logic [WINDOW-1:0]     match;
  logic [WINDOW-1:0]     keep;
  logic [IdxBits-1:0]    hit_idx;

  // Compare against every held entry; held values are distinct, so at most
  // one position matches
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      match[i] = window_valid[i] && (window_value[i] == key);
    end
  end

  assign hit = |match;

  // Encode the one-hot match into a position
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (match[i]) begin
        hit_idx = hit_idx | IdxBits'(i);
      end
    end
  end

  assign hit_len = LEN_BITS'(hit_idx) + LEN_BITS'(1);

  // Keep only entries newer than the match
  assign keep = hit ? (match - {{(WINDOW-1){1'b0}}, 1'b1}) : '1;

  // Valid marks: clear on reset or end of sequence, else shift
  always_ff @(posedge clk) begin
    if (rst || (shift_en && clear)) begin
      window_valid <= '0;
    end else if (shift_en) begin
      window_valid <= {window_valid[WINDOW-2:0] & keep[WINDOW-2:0], 1'b1};
    end
  end

  // Values: shift line, newest at position 0
  always_ff @(posedge clk) begin
    if (shift_en) begin
      window_value[0] <= key;
      for (int i = 1; i < WINDOW; i++) begin
        window_value[i] <= window_value[i-1];
      end
    end
  end

endmodule

@@ hw/rtl/longest_distinct_run.sv @@
// Result path: the last word is held in the input register, then its result in the result register on m_axis.
// Throughput: one input word per cycle; the window compare and shift in a
//   single stage between the input register and the state registers.
// Stalls only when a final word meets a result still waiting to be taken.
// Reset (rst, synchronous): empties the window, clears run and best lengths,
//   drops any pending word and result.
// ----------------------------------------------------------------------------
// longest_distinct_run: longest run of a sequence without repeated values
// Tracks the current repeat-free run in a shift window and reports the best
// length, with a saturation flag, when the final word of a sequence arrives.
// ----------------------------------------------------------------------------
module longest_distinct_run #(
  parameter int WINDOW     = ldr_pkg::WINDOW_DEFAULT,
  parameter int VALUE_BITS = ldr_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  // s_axis_tdata: [31:0] value
  input  logic [ldr_pkg::DATA_BITS-1:0]      s_axis_tdata,
  input  logic                               s_axis_tlast,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // m_axis_tdata: [6:0] longest, [7] zero
  output logic [ldr_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
  // m_axis_tuser: [0] saturated
  output logic                               m_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready
);

  import ldr_pkg::*;

  localparam int LenBits  = $clog2(WINDOW + 1);
  localparam int WideBits = (LenBits > LONGEST_BITS) ? LenBits : LONGEST_BITS;

  // Input register
  logic                  in_valid;
  logic [VALUE_BITS-1:0] in_value;
  logic                  in_last;

  // Run state
  logic [LenBits-1:0]    run_length, run_length_next;
  logic [LenBits-1:0]    best_length, best_length_next;
  logic                  overflow_seen, overflow_seen_next;
  logic [LenBits:0]      run_inc;

  // Result register
  logic                      out_valid;
  logic [LONGEST_BITS-1:0]   out_longest;
  logic                      out_saturated;

  logic                  advance;
  logic                  hit;
  logic [LenBits-1:0]    hit_len;
  logic [WideBits-1:0]   best_wide;
  logic [LONGEST_BITS-1:0] longest_next;
  logic                  saturated_next;

  // Process the held word unless it is final and the result slot is blocked
  assign advance       = in_valid && (!in_last || !out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Hold the incoming word
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_value <= VALUE_BITS'(s_axis_tdata);
      in_last  <= s_axis_tlast;
    end
  end

  ldr_window #(
    .WINDOW     (WINDOW),
    .VALUE_BITS (VALUE_BITS),
    .LEN_BITS   (LenBits)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .shift_en (advance),
    .clear    (in_last),
    .key      (in_value),
    .hit      (hit),
    .hit_len  (hit_len)
  );

  // Advance the run length; saturate at the window size
  assign run_inc = {1'b0, run_length} + (LenBits+1)'(1);

  always_comb begin
    overflow_seen_next = overflow_seen;
    if (hit) begin
      run_length_next = hit_len;
    end else if (run_inc >= (LenBits+1)'(WINDOW)) begin
      run_length_next    = LenBits'(WINDOW);
      overflow_seen_next = 1'b1;
    end else begin
      run_length_next = run_inc[LenBits-1:0];
    end
    best_length_next = (run_length_next > best_length) ? run_length_next : best_length;
  end

  // Clamp the best length to the result field
  assign best_wide = WideBits'(best_length_next);

  always_comb begin
    if (best_wide > WideBits'(LONGEST_MAX)) begin
      longest_next   = LONGEST_BITS'(LONGEST_MAX);
      saturated_next = 1'b1;
    end else begin
      longest_next   = best_wide[LONGEST_BITS-1:0];
      saturated_next = overflow_seen_next;
    end
  end

  // Update run state; clear it after the final word
  always_ff @(posedge clk) begin
    if (rst || (advance && in_last)) begin
      run_length    <= '0;
      best_length   <= '0;
      overflow_seen <= 1'b0;
    end else if (advance) begin
      run_length    <= run_length_next;
      best_length   <= best_length_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_longest   <= longest_next;
      out_saturated <= saturated_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TDATA_BITS'(out_longest);
  assign m_axis_tuser  = out_saturated;

endmodule

@@ hw/rtl/ldr_checker.sv @@
// ----------------------------------------------------------------------------
// ldr_checker: port-level checks for longest_distinct_run
// Watches the result stream for reset, hold and value consistency.
// ----------------------------------------------------------------------------
module ldr_checker #(
  parameter int WINDOW = ldr_pkg::WINDOW_DEFAULT
) (
  input logic                               clk,
  input logic                               rst,
  input logic [ldr_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
  input logic                               m_axis_tuser,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready
);

  import ldr_pkg::*;

  localparam int SatLen = (WINDOW > LONGEST_MAX) ? LONGEST_MAX : WINDOW;

  // No result straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result shown after reset");

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Every sequence has at least one element
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[LONGEST_BITS-1:0] != '0)
    else $error("zero-length result");

  // Saturation means the run filled the window or the length was clamped
  a_sat_len: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[LONGEST_BITS-1:0] == LONGEST_BITS'(SatLen))
    else $error("saturated flag with short length");

  // Reaching the window size always sets the flag; a clamped length can be
  // reached without a full window, so only a window that fits is checked
  a_sat_set: assert property (@(posedge clk) disable iff (rst)
    (WINDOW <= LONGEST_MAX) && m_axis_tvalid &&
      (m_axis_tdata[LONGEST_BITS-1:0] == LONGEST_BITS'(SatLen)) |->
      m_axis_tuser)
    else $error("full-window length without saturated flag");

endmodule

bind longest_distinct_run ldr_checker #(
  .WINDOW (WINDOW)
) u_ldr_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
